// ===== rtl/ivs_pkg.sv =====
// Shared widths, status codes, sideband types and rounding helper for the intercept solver.
package ivs_pkg;

  // Field widths.
  localparam int COORD_W = 32;
  localparam int RANGE_W = COORD_W + 1;
  localparam int SPEED_W = COORD_W - 1;

  // Unit vector components are Q2.30; the larger normalised range magnitude sits in [2^29, 2^30).
  localparam int UNIT_BITS = 30;
  localparam int NORM_W    = UNIT_BITS;
  localparam int SQSUM_W   = 2 * NORM_W + 1;

  // Square root unit: 62-bit radicand, 31-bit root, one root bit per stage.
  localparam int SQ_W     = 62;
  localparam int ROOT_W   = SQ_W / 2;
  localparam int SQRT_LAT = ROOT_W + 1;

  // Divider: 61-bit numerator, 31-bit divisor and quotient, one quotient bit per stage.
  localparam int NUM_W   = NORM_W + UNIT_BITS + 1;
  localparam int QUO_W   = 31;
  localparam int DIV_LAT = QUO_W + 1;

  // Along and normal parts, and the rounded products, fit in 34 signed bits.
  localparam int PART_W = 34;
  localparam int PROD_W = 64;
  localparam int SUM_W  = 36;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_ZERO_RANGE = 2'd1,
    ST_TOO_SLOW   = 2'd2
  } status_t;

  // Sideband that travels beside the range length root.
  typedef struct packed {
    logic signed [RANGE_W-1:0] dx;
    logic signed [RANGE_W-1:0] dy;
    logic signed [COORD_W-1:0] vx;
    logic signed [COORD_W-1:0] vy;
    logic [SPEED_W-1:0]        spd;
    logic [NORM_W-1:0]         mx;
    logic [NORM_W-1:0]         my;
    logic                      zero;
  } side_len_t;

  // Sideband that travels beside the unit vector dividers.
  typedef struct packed {
    logic signed [RANGE_W-1:0] dx;
    logic signed [RANGE_W-1:0] dy;
    logic signed [COORD_W-1:0] vx;
    logic signed [COORD_W-1:0] vy;
    logic [SPEED_W-1:0]        spd;
    logic                      zero;
  } side_div_t;

  // Sideband that travels beside the interceptor speed root.
  typedef struct packed {
    logic signed [RANGE_W-1:0] dx;
    logic signed [RANGE_W-1:0] dy;
    logic signed [COORD_W-1:0] vx;
    logic signed [COORD_W-1:0] vy;
    logic signed [COORD_W-1:0] ux;
    logic signed [COORD_W-1:0] uy;
    logic signed [PART_W-1:0]  au;
    logic signed [PART_W-1:0]  av;
    logic                      zero;
    logic                      slow;
  } side_spd_t;

  // Drops the unit fraction bits, rounding to nearest with ties away from zero.
  function automatic logic signed [PART_W-1:0] round_unit(input logic signed [PROD_W-1:0] x);
    logic [PROD_W-1:0] m;
    logic [PROD_W-1:0] q;
    m = x[PROD_W-1] ? PROD_W'(-x) : PROD_W'(x);
    q = (m + (PROD_W'(1) << (UNIT_BITS - 1))) >> UNIT_BITS;
    return x[PROD_W-1] ? -$signed(q[PART_W-1:0]) : $signed(q[PART_W-1:0]);
  endfunction

endpackage

// ===== rtl/ivs_isqrt.sv =====
// Pipelined floor square root, one root bit resolved per stage.
module ivs_isqrt (
  input  logic                         clk,
  input  logic                         en,
  input  logic [ivs_pkg::SQ_W-1:0]     radicand,
  output logic [ivs_pkg::ROOT_W-1:0]   root
);

  logic [ivs_pkg::SQ_W-1:0]   rem_q  [ivs_pkg::ROOT_W];
  logic [ivs_pkg::ROOT_W-1:0] root_q [ivs_pkg::ROOT_W+1];
  logic [ivs_pkg::SQ_W-1:0]   trial  [ivs_pkg::ROOT_W];

  // Trial subtrahend for stage k: 2*root*2^i + 4^i with i the bit being decided.
  always_comb begin
    for (int k = 0; k < ivs_pkg::ROOT_W; k++) begin
      trial[k] = (ivs_pkg::SQ_W'(root_q[k]) << (ivs_pkg::ROOT_W - k))
               + (ivs_pkg::SQ_W'(1) << (2 * (ivs_pkg::ROOT_W - 1 - k)));
    end
  end

  // Each stage keeps the remainder and the root bits decided so far.
  always_ff @(posedge clk) begin
    if (en) begin
      rem_q[0]  <= radicand;
      root_q[0] <= '0;
      for (int k = 0; k < ivs_pkg::ROOT_W - 1; k++) begin
        if (rem_q[k] >= trial[k]) begin
          rem_q[k+1]  <= rem_q[k] - trial[k];
          root_q[k+1] <= root_q[k] | (ivs_pkg::ROOT_W'(1) << (ivs_pkg::ROOT_W - 1 - k));
        end else begin
          rem_q[k+1]  <= rem_q[k];
          root_q[k+1] <= root_q[k];
        end
      end
      root_q[ivs_pkg::ROOT_W] <= root_q[ivs_pkg::ROOT_W-1]
        | ivs_pkg::ROOT_W'(rem_q[ivs_pkg::ROOT_W-1] >= trial[ivs_pkg::ROOT_W-1]);
    end
  end

  assign root = root_q[ivs_pkg::ROOT_W];

endmodule

// ===== rtl/ivs_div.sv =====
// Pipelined restoring divider, one quotient bit resolved per stage.
module ivs_div (
  input  logic                       clk,
  input  logic                       en,
  input  logic [ivs_pkg::NUM_W-1:0]  num,
  input  logic [ivs_pkg::QUO_W-1:0]  den,
  output logic [ivs_pkg::QUO_W-1:0]  quo
);

  localparam int TW = ivs_pkg::NUM_W + 1;

  logic [TW-1:0]                rem_q [ivs_pkg::QUO_W];
  logic [ivs_pkg::QUO_W-1:0]    den_q [ivs_pkg::QUO_W];
  logic [ivs_pkg::QUO_W-1:0]    quo_q [ivs_pkg::QUO_W+1];
  logic [TW-1:0]                trial [ivs_pkg::QUO_W];

  // Divisor aligned to the quotient bit decided in each stage.
  always_comb begin
    for (int k = 0; k < ivs_pkg::QUO_W; k++) begin
      trial[k] = TW'(den_q[k]) << (ivs_pkg::QUO_W - 1 - k);
    end
  end

  // The quotient is known to fit, so the remainder stays below twice each trial.
  always_ff @(posedge clk) begin
    if (en) begin
      rem_q[0] <= TW'(num);
      den_q[0] <= den;
      quo_q[0] <= '0;
      for (int k = 0; k < ivs_pkg::QUO_W - 1; k++) begin
        den_q[k+1] <= den_q[k];
        if (rem_q[k] >= trial[k]) begin
          rem_q[k+1] <= rem_q[k] - trial[k];
          quo_q[k+1] <= quo_q[k] | (ivs_pkg::QUO_W'(1) << (ivs_pkg::QUO_W - 1 - k));
        end else begin
          rem_q[k+1] <= rem_q[k];
          quo_q[k+1] <= quo_q[k];
        end
      end
      quo_q[ivs_pkg::QUO_W] <= quo_q[ivs_pkg::QUO_W-1]
        | ivs_pkg::QUO_W'(rem_q[ivs_pkg::QUO_W-1] >= trial[ivs_pkg::QUO_W-1]);
    end
  end

  assign quo = quo_q[ivs_pkg::QUO_W];

endmodule

// ===== rtl/intercept_velocity_solver.sv =====
// Top level of the pipelined 2-D intercept velocity solver.
//
//   channel  direction  handshake             beat contents
//   in       into       in_valid / in_ready   positions, target velocity, interceptor speed
//   out      out of     out_valid / out_ready range vector, interceptor velocity, status
//
// One beat is accepted per cycle while in_ready is high; a beat passes 112 register stages,
// including the output register, before out_valid rises.
// Most of that depth is two 32-stage square root pipelines and a 32-stage divider pair.
// The whole pipeline advances together whenever the output register is empty or taken.
// A stall freezes every stage, so nothing is lost or repeated.
// Synchronous reset clears the valid bits only.
module intercept_velocity_solver (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic signed [ivs_pkg::COORD_W-1:0]     target_x,
  input  logic signed [ivs_pkg::COORD_W-1:0]     target_y,
  input  logic signed [ivs_pkg::COORD_W-1:0]     chaser_x,
  input  logic signed [ivs_pkg::COORD_W-1:0]     chaser_y,
  input  logic signed [ivs_pkg::COORD_W-1:0]     target_vx,
  input  logic signed [ivs_pkg::COORD_W-1:0]     target_vy,
  input  logic [ivs_pkg::SPEED_W-1:0]            chaser_speed,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [ivs_pkg::RANGE_W-1:0]     range_dx,
  output logic signed [ivs_pkg::RANGE_W-1:0]     range_dy,
  output logic signed [ivs_pkg::COORD_W-1:0]     chaser_vx,
  output logic signed [ivs_pkg::COORD_W-1:0]     chaser_vy,
  output logic [1:0]                             status
);

  localparam int RW = ivs_pkg::RANGE_W;
  localparam int CW = ivs_pkg::COORD_W;
  localparam int NW = ivs_pkg::NORM_W;
  localparam int PW = ivs_pkg::PROD_W;
  localparam int AW = ivs_pkg::PART_W;

  // Saturation limits of the velocity outputs.
  localparam logic signed [ivs_pkg::SUM_W-1:0] W_MAX =
    ivs_pkg::SUM_W'(signed'({1'b0, {(CW-1){1'b1}}}));
  localparam logic signed [ivs_pkg::SUM_W-1:0] W_MIN = -W_MAX - ivs_pkg::SUM_W'(1);

  logic en;

  // Valid bits of the plain stages and of the delay lines.
  logic v1, v2, v3, v4, v5, v6, v7, v8, v9, v10, v11, v12, v13, v14, v15;
  logic vlen [ivs_pkg::SQRT_LAT];
  logic vdiv [ivs_pkg::DIV_LAT];
  logic vspd [ivs_pkg::SQRT_LAT];

  // Stage 1: range vector.
  logic signed [RW-1:0] s1_dx, s1_dy;
  logic signed [CW-1:0] s1_vx, s1_vy;
  logic [ivs_pkg::SPEED_W-1:0] s1_spd;

  // Stage 2: magnitudes.
  logic signed [RW-1:0] s2_dx, s2_dy;
  logic signed [CW-1:0] s2_vx, s2_vy;
  logic [ivs_pkg::SPEED_W-1:0] s2_spd;
  logic [RW-1:0] s2_mx, s2_my;
  logic s2_zero;

  // Stage 3: normalising shift amounts.
  logic signed [RW-1:0] s3_dx, s3_dy;
  logic signed [CW-1:0] s3_vx, s3_vy;
  logic [ivs_pkg::SPEED_W-1:0] s3_spd;
  logic [RW-1:0] s3_mx, s3_my;
  logic s3_zero;
  logic [1:0] s3_shr;
  logic [4:0] s3_shl;
  logic [RW-1:0] mmax;
  logic [5:0] lead;

  // Stage 4: normalised magnitudes.
  ivs_pkg::side_div_t s4_side;
  logic [NW-1:0] s4_mx, s4_my;

  // Stage 5: squares.
  ivs_pkg::side_div_t s5_side;
  logic [NW-1:0] s5_mx, s5_my;
  logic [2*NW-1:0] s5_sqx, s5_sqy;

  // Stage 6: sum of squares, start of the length root.
  ivs_pkg::side_len_t s6_side;
  logic [ivs_pkg::SQSUM_W-1:0] s6_sum;

  ivs_pkg::side_len_t dl_len [ivs_pkg::SQRT_LAT];
  logic [ivs_pkg::ROOT_W-1:0] len;

  // Stage 7: divider operands.
  ivs_pkg::side_div_t s7_side;
  logic [ivs_pkg::NUM_W-1:0] s7_numx, s7_numy;
  logic [ivs_pkg::QUO_W-1:0] s7_len;

  ivs_pkg::side_div_t dl_div [ivs_pkg::DIV_LAT];
  logic [ivs_pkg::QUO_W-1:0] qx, qy;

  // Stage 8: signed unit vector.
  ivs_pkg::side_div_t s8_side;
  logic signed [CW-1:0] s8_ux, s8_uy;

  // Stage 9: velocity products.
  ivs_pkg::side_div_t s9_side;
  logic signed [CW-1:0] s9_ux, s9_uy;
  logic signed [PW-1:0] s9_pxx, s9_pyy, s9_pxy, s9_pyx;

  // Stage 10: dot and cross sums.
  ivs_pkg::side_div_t s10_side;
  logic signed [CW-1:0] s10_ux, s10_uy;
  logic signed [PW-1:0] s10_dot, s10_crs;

  // Stage 11: along and normal parts.
  ivs_pkg::side_div_t s11_side;
  logic signed [CW-1:0] s11_ux, s11_uy;
  logic signed [AW-1:0] s11_a, s11_n;

  // Stage 12: squares and the along-part products.
  ivs_pkg::side_div_t s12_side;
  logic signed [CW-1:0] s12_ux, s12_uy;
  logic [PW-1:0] s12_n2, s12_s2;
  logic signed [PW-1:0] s12_aux, s12_auy;
  logic [AW-1:0] nmag;

  // Stage 13: speed radicand, start of the speed root.
  ivs_pkg::side_spd_t s13_side;
  logic [ivs_pkg::SQ_W-1:0] s13_rad;

  ivs_pkg::side_spd_t dl_spd [ivs_pkg::SQRT_LAT];
  logic [ivs_pkg::ROOT_W-1:0] root;

  // Stage 14: root products.
  ivs_pkg::side_spd_t s14_side;
  logic signed [PW-1:0] s14_rux, s14_ruy;

  // Stage 15: rounded root products.
  ivs_pkg::side_spd_t s15_side;
  logic signed [AW-1:0] s15_ru, s15_rv;

  logic signed [ivs_pkg::SUM_W-1:0] wx, wy;

  // The pipeline moves as one whenever the output register can take a beat.
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // Valid bits follow their data through every stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0; v4 <= 1'b0; v5 <= 1'b0;
      v6 <= 1'b0; v7 <= 1'b0; v8 <= 1'b0; v9 <= 1'b0; v10 <= 1'b0;
      v11 <= 1'b0; v12 <= 1'b0; v13 <= 1'b0; v14 <= 1'b0; v15 <= 1'b0;
      out_valid <= 1'b0;
      for (int k = 0; k < ivs_pkg::SQRT_LAT; k++) begin
        vlen[k] <= 1'b0;
        vspd[k] <= 1'b0;
      end
      for (int k = 0; k < ivs_pkg::DIV_LAT; k++) begin
        vdiv[k] <= 1'b0;
      end
    end else if (en) begin
      v1 <= in_valid; v2 <= v1; v3 <= v2; v4 <= v3; v5 <= v4; v6 <= v5;
      vlen[0] <= v6;
      for (int k = 1; k < ivs_pkg::SQRT_LAT; k++) begin
        vlen[k] <= vlen[k-1];
      end
      v7 <= vlen[ivs_pkg::SQRT_LAT-1];
      vdiv[0] <= v7;
      for (int k = 1; k < ivs_pkg::DIV_LAT; k++) begin
        vdiv[k] <= vdiv[k-1];
      end
      v8 <= vdiv[ivs_pkg::DIV_LAT-1];
      v9 <= v8; v10 <= v9; v11 <= v10; v12 <= v11; v13 <= v12;
      vspd[0] <= v13;
      for (int k = 1; k < ivs_pkg::SQRT_LAT; k++) begin
        vspd[k] <= vspd[k-1];
      end
      v14 <= vspd[ivs_pkg::SQRT_LAT-1];
      v15 <= v14;
      out_valid <= v15;
    end
  end

  // Largest magnitude and the position of its leading one.
  always_comb begin
    mmax = (s2_mx > s2_my) ? s2_mx : s2_my;
    lead = '0;
    for (int i = 0; i < RW; i++) begin
      if (mmax[i]) begin
        lead = 6'(i);
      end
    end
  end

  // Front stages: range, magnitudes, normalisation, squares.
  always_ff @(posedge clk) begin
    if (en) begin
      s1_dx  <= RW'(target_x) - RW'(chaser_x);
      s1_dy  <= RW'(target_y) - RW'(chaser_y);
      s1_vx  <= target_vx;
      s1_vy  <= target_vy;
      s1_spd <= chaser_speed;

      s2_dx   <= s1_dx;
      s2_dy   <= s1_dy;
      s2_vx   <= s1_vx;
      s2_vy   <= s1_vy;
      s2_spd  <= s1_spd;
      s2_mx   <= s1_dx[RW-1] ? RW'(-s1_dx) : RW'(s1_dx);
      s2_my   <= s1_dy[RW-1] ? RW'(-s1_dy) : RW'(s1_dy);
      s2_zero <= (s1_dx == '0) && (s1_dy == '0);

      s3_dx   <= s2_dx;
      s3_dy   <= s2_dy;
      s3_vx   <= s2_vx;
      s3_vy   <= s2_vy;
      s3_spd  <= s2_spd;
      s3_mx   <= s2_mx;
      s3_my   <= s2_my;
      s3_zero <= s2_zero;
      s3_shr  <= (lead > 6'(NW - 1)) ? 2'(lead - 6'(NW - 1)) : 2'd0;
      s3_shl  <= (lead < 6'(NW - 1)) ? 5'(6'(NW - 1) - lead) : 5'd0;

      s4_side.dx   <= s3_dx;
      s4_side.dy   <= s3_dy;
      s4_side.vx   <= s3_vx;
      s4_side.vy   <= s3_vy;
      s4_side.spd  <= s3_spd;
      s4_side.zero <= s3_zero;
      s4_mx <= NW'((s3_mx >> s3_shr) << s3_shl);
      s4_my <= NW'((s3_my >> s3_shr) << s3_shl);

      s5_side <= s4_side;
      s5_mx   <= s4_mx;
      s5_my   <= s4_my;
      s5_sqx  <= (2*NW)'(s4_mx) * (2*NW)'(s4_mx);
      s5_sqy  <= (2*NW)'(s4_my) * (2*NW)'(s4_my);

      s6_side.dx   <= s5_side.dx;
      s6_side.dy   <= s5_side.dy;
      s6_side.vx   <= s5_side.vx;
      s6_side.vy   <= s5_side.vy;
      s6_side.spd  <= s5_side.spd;
      s6_side.zero <= s5_side.zero;
      s6_side.mx   <= s5_mx;
      s6_side.my   <= s5_my;
      s6_sum <= ivs_pkg::SQSUM_W'(s5_sqx) + ivs_pkg::SQSUM_W'(s5_sqy);
    end
  end

  // Length of the normalised range vector.
  ivs_isqrt u_len_sqrt (
    .clk      (clk),
    .en       (en),
    .radicand (ivs_pkg::SQ_W'(s6_sum)),
    .root     (len)
  );

  // Sideband delay lines matched to the root and divider latencies.
  always_ff @(posedge clk) begin
    if (en) begin
      dl_len[0] <= s6_side;
      for (int k = 1; k < ivs_pkg::SQRT_LAT; k++) begin
        dl_len[k] <= dl_len[k-1];
      end
      dl_div[0] <= s7_side;
      for (int k = 1; k < ivs_pkg::DIV_LAT; k++) begin
        dl_div[k] <= dl_div[k-1];
      end
      dl_spd[0] <= s13_side;
      for (int k = 1; k < ivs_pkg::SQRT_LAT; k++) begin
        dl_spd[k] <= dl_spd[k-1];
      end
    end
  end

  // Divider operands: magnitude scaled to Q.30 plus half the length for rounding.
  always_ff @(posedge clk) begin
    if (en) begin
      s7_side.dx   <= dl_len[ivs_pkg::SQRT_LAT-1].dx;
      s7_side.dy   <= dl_len[ivs_pkg::SQRT_LAT-1].dy;
      s7_side.vx   <= dl_len[ivs_pkg::SQRT_LAT-1].vx;
      s7_side.vy   <= dl_len[ivs_pkg::SQRT_LAT-1].vy;
      s7_side.spd  <= dl_len[ivs_pkg::SQRT_LAT-1].spd;
      s7_side.zero <= dl_len[ivs_pkg::SQRT_LAT-1].zero;
      s7_numx <= ivs_pkg::NUM_W'({dl_len[ivs_pkg::SQRT_LAT-1].mx, ivs_pkg::UNIT_BITS'(0)})
               + ivs_pkg::NUM_W'(len >> 1);
      s7_numy <= ivs_pkg::NUM_W'({dl_len[ivs_pkg::SQRT_LAT-1].my, ivs_pkg::UNIT_BITS'(0)})
               + ivs_pkg::NUM_W'(len >> 1);
      s7_len  <= ivs_pkg::QUO_W'(len);
    end
  end

  ivs_div u_div_x (
    .clk (clk),
    .en  (en),
    .num (s7_numx),
    .den (s7_len),
    .quo (qx)
  );

  ivs_div u_div_y (
    .clk (clk),
    .en  (en),
    .num (s7_numy),
    .den (s7_len),
    .quo (qy)
  );

  assign nmag = s11_n[AW-1] ? AW'(-s11_n) : AW'(s11_n);

  // Middle stages: unit vector, projections, squares of speed and normal part, speed radicand.
  always_ff @(posedge clk) begin
    if (en) begin
      s8_side <= dl_div[ivs_pkg::DIV_LAT-1];
      s8_ux   <= dl_div[ivs_pkg::DIV_LAT-1].dx[RW-1] ? -$signed(CW'(qx)) : $signed(CW'(qx));
      s8_uy   <= dl_div[ivs_pkg::DIV_LAT-1].dy[RW-1] ? -$signed(CW'(qy)) : $signed(CW'(qy));

      s9_side <= s8_side;
      s9_ux   <= s8_ux;
      s9_uy   <= s8_uy;
      s9_pxx  <= PW'(s8_side.vx) * PW'(s8_ux);
      s9_pyy  <= PW'(s8_side.vy) * PW'(s8_uy);
      s9_pxy  <= PW'(s8_side.vx) * PW'(s8_uy);
      s9_pyx  <= PW'(s8_side.vy) * PW'(s8_ux);

      s10_side <= s9_side;
      s10_ux   <= s9_ux;
      s10_uy   <= s9_uy;
      s10_dot  <= s9_pxx + s9_pyy;
      s10_crs  <= s9_pxy - s9_pyx;

      s11_side <= s10_side;
      s11_ux   <= s10_ux;
      s11_uy   <= s10_uy;
      s11_a    <= ivs_pkg::round_unit(s10_dot);
      s11_n    <= ivs_pkg::round_unit(s10_crs);

      s12_side <= s11_side;
      s12_ux   <= s11_ux;
      s12_uy   <= s11_uy;
      s12_n2   <= PW'(nmag) * PW'(nmag);
      s12_s2   <= PW'(s11_side.spd) * PW'(s11_side.spd);
      s12_aux  <= PW'(s11_a) * PW'(s11_ux);
      s12_auy  <= PW'(s11_a) * PW'(s11_uy);

      s13_side.dx   <= s12_side.dx;
      s13_side.dy   <= s12_side.dy;
      s13_side.vx   <= s12_side.vx;
      s13_side.vy   <= s12_side.vy;
      s13_side.ux   <= s12_ux;
      s13_side.uy   <= s12_uy;
      s13_side.au   <= ivs_pkg::round_unit(s12_aux);
      s13_side.av   <= ivs_pkg::round_unit(s12_auy);
      s13_side.zero <= s12_side.zero;
      s13_side.slow <= s12_s2 < s12_n2;
      s13_rad <= (s12_s2 < s12_n2) ? '0 : ivs_pkg::SQ_W'(s12_s2 - s12_n2);
    end
  end

  // Interceptor speed along the range.
  ivs_isqrt u_spd_sqrt (
    .clk      (clk),
    .en       (en),
    .radicand (s13_rad),
    .root     (root)
  );

  // Final velocity before saturation.
  assign wx = ivs_pkg::SUM_W'(s15_side.vx) - ivs_pkg::SUM_W'(s15_side.au)
            + ivs_pkg::SUM_W'(s15_ru);
  assign wy = ivs_pkg::SUM_W'(s15_side.vy) - ivs_pkg::SUM_W'(s15_side.av)
            + ivs_pkg::SUM_W'(s15_rv);

  // Back stages: root products, rounding, saturation into the output register.
  always_ff @(posedge clk) begin
    if (en) begin
      s14_side <= dl_spd[ivs_pkg::SQRT_LAT-1];
      s14_rux  <= PW'(signed'({1'b0, root})) * PW'(dl_spd[ivs_pkg::SQRT_LAT-1].ux);
      s14_ruy  <= PW'(signed'({1'b0, root})) * PW'(dl_spd[ivs_pkg::SQRT_LAT-1].uy);

      s15_side <= s14_side;
      s15_ru   <= ivs_pkg::round_unit(s14_rux);
      s15_rv   <= ivs_pkg::round_unit(s14_ruy);

      range_dx <= s15_side.dx;
      range_dy <= s15_side.dy;
      if (s15_side.zero) begin
        chaser_vx <= '0;
        chaser_vy <= '0;
        status    <= ivs_pkg::ST_ZERO_RANGE;
      end else begin
        if (wx > W_MAX) begin
          chaser_vx <= {1'b0, {(CW-1){1'b1}}};
        end else if (wx < W_MIN) begin
          chaser_vx <= {1'b1, {(CW-1){1'b0}}};
        end else begin
          chaser_vx <= CW'(wx);
        end
        if (wy > W_MAX) begin
          chaser_vy <= {1'b0, {(CW-1){1'b1}}};
        end else if (wy < W_MIN) begin
          chaser_vy <= {1'b1, {(CW-1){1'b0}}};
        end else begin
          chaser_vy <= CW'(wy);
        end
        status <= s15_side.slow ? ivs_pkg::ST_TOO_SLOW : ivs_pkg::ST_OK;
      end
    end
  end

endmodule
